### rtl/core/salc_pkg.sv
// Shared types, constants and helper functions of the set-associative cache tag engine.
// Used by the channel interfaces, the top level and its checker; depends on nothing.
`default_nettype none

package salc_pkg;

    localparam int SALC_MAX_SET_BITS = 6;
    localparam int SALC_MAX_WAYS     = 8;
    localparam int SALC_ADDR_WIDTH   = 64;

    localparam int ADDR_IN_W  = 64;
    localparam int AGE_W      = 3;
    localparam int CNT_W      = 32;
    localparam int WAY_OUT_W  = 3;
    localparam int SET_OUT_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

    typedef enum logic [1:0] {
        OUTC_HIT   = 2'd0,
        OUTC_FILL  = 2'd1,
        OUTC_EVICT = 2'd2
    } outcome_t;

    function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] a);
        return (a == AGE_MAX) ? a : a + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

### rtl/core/salc_if.sv
// Valid/ready channel interfaces: address requests, lookup responses and register writes.
// Depends on salc_pkg for field widths.
`default_nettype none

interface salc_req_if
    import salc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ADDR_IN_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface salc_rsp_if
    import salc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           outcome;
    logic [WAY_OUT_W-1:0] way_used;
    logic [SET_OUT_W-1:0] set_used;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     miss_total;
    logic [CNT_W-1:0]     eviction_total;

    modport source (output valid, output outcome, output way_used, output set_used,
                    output hit_total, output miss_total, output eviction_total, input ready);
    modport sink   (input valid, input outcome, input way_used, input set_used,
                    input hit_total, input miss_total, input eviction_total, output ready);
endinterface

interface salc_cfg_if
    import salc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/set_assoc_lru_cache_tags.sv
// Each address is handled in a read step, which loads the set's row as the address is accepted, and a lookup step,
// which compares, updates and writes back. A new address is accepted only after the last one is written back.
// A result waits in the output register; the next lookup finishes only once that beat is taken.
// After reset a clearing pass zeroes the metadata row of each of the 2**MAX_SET_BITS sets (64 by default),
// during which no address is accepted. Register writes are taken at any time.
// Depends on salc_pkg and the channel interfaces in salc_if.sv.
`default_nettype none

module set_assoc_lru_cache_tags
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = SALC_MAX_SET_BITS,
    parameter int MAX_WAYS     = SALC_MAX_WAYS,
    parameter int ADDR_WIDTH   = SALC_ADDR_WIDTH
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    salc_cfg_if.sink    cfg,
    salc_req_if.sink    req,
    salc_rsp_if.source  rsp
);

    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
    localparam int SHIFT_W   = 7;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } state_t;

    typedef logic [MAX_WAYS-1:0][AGE_W:0]        meta_row_t;
    typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_row_t;

    meta_row_t meta_mem [NUM_SETS];
    tag_row_t  tag_mem  [NUM_SETS];

    state_t                 state_reg, state_next;
    logic [SET_W-1:0]       clr_cnt_reg;
    logic [2:0]             set_bits_reg;
    logic [5:0]             offset_bits_reg;
    logic [3:0]             ways_reg;
    logic [CNT_W-1:0]       hits_reg, misses_reg, evicts_reg;
    logic                   out_valid_reg;
    outcome_t               outcome_reg;
    logic [WAY_OUT_W-1:0]   way_out_reg;
    logic [SET_OUT_W-1:0]   set_out_reg;
    logic [SET_W-1:0]       set_reg;
    logic [ADDR_WIDTH-1:0]  tag_reg;
    meta_row_t              meta_rd_reg;
    tag_row_t               tag_rd_reg;

    logic [2:0]             sbits_eff;
    logic [SHIFT_W-1:0]     tag_shift;
    logic [ADDR_WIDTH-1:0]  addr_cut;
    logic [ADDR_WIDTH-1:0]  addr_shifted;
    logic [SET_W-1:0]       set_mask;
    logic [SET_W-1:0]       set_idx;
    logic [ADDR_WIDTH-1:0]  tag_idx;
    logic                   req_beat;

    logic [WAY_CNT_W-1:0]   ways_eff;
    logic [MAX_WAYS-1:0]    in_use;
    logic                   hit;
    logic [WAY_W-1:0]       hit_way;
    logic [AGE_W-1:0]       hit_age;
    logic                   any_free;
    logic [WAY_W-1:0]       free_way;
    logic [WAY_W-1:0]       oldest_way;
    logic [AGE_W-1:0]       oldest_age;
    logic [WAY_W-1:0]       sel_way;
    outcome_t               outcome_new;
    meta_row_t              meta_new;
    tag_row_t               tag_new;
    logic                   look_done;
    logic [31:0]            way_ext;
    logic [31:0]            set_ext;

    function automatic logic [AGE_W-1:0] age_of(input int w);
        return meta_rd_reg[w][AGE_W-1:0];
    endfunction

    // Address split: offset, then set index, then tag.
    always_comb
    begin
        if (32'(set_bits_reg) > MAX_SET_BITS)
        begin
            sbits_eff = 3'(MAX_SET_BITS);
        end
        else
        begin
            sbits_eff = set_bits_reg;
        end
        tag_shift    = SHIFT_W'(sbits_eff) + SHIFT_W'(offset_bits_reg);
        addr_cut     = req.address[ADDR_WIDTH-1:0];
        addr_shifted = addr_cut >> offset_bits_reg;
        set_mask     = ~({SET_W{1'b1}} << sbits_eff);
        set_idx      = addr_shifted[SET_W-1:0] & set_mask;
        tag_idx      = addr_cut >> tag_shift;
    end

    assign req.ready = (state_reg == S_IDLE);
    assign req_beat  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Lookup and replacement over the row registered when the address was accepted.
    always_comb
    begin
        if (ways_reg == 4'd0)
        begin
            ways_eff = WAY_CNT_W'(1);
        end
        else if (32'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = WAY_CNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WAY_CNT_W'(ways_reg);
        end

        hit        = 1'b0;
        hit_way    = '0;
        hit_age    = '0;
        any_free   = 1'b0;
        free_way   = '0;
        oldest_way = '0;
        oldest_age = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w] = WAY_CNT_W'(w) < ways_eff;
            if (in_use[w] && meta_rd_reg[w][AGE_W] && (age_of(w) >= oldest_age))
            begin
                oldest_age = age_of(w);
                oldest_way = WAY_W'(w);
            end
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (in_use[w] && meta_rd_reg[w][AGE_W] && (tag_rd_reg[w] == tag_reg))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
                hit_age = age_of(w);
            end
            if (in_use[w] && !meta_rd_reg[w][AGE_W])
            begin
                any_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end

        if (hit)
        begin
            sel_way     = hit_way;
            outcome_new = OUTC_HIT;
        end
        else if (any_free)
        begin
            sel_way     = free_way;
            outcome_new = OUTC_FILL;
        end
        else
        begin
            sel_way     = oldest_way;
            outcome_new = OUTC_EVICT;
        end

        meta_new = meta_rd_reg;
        tag_new  = tag_rd_reg;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && meta_rd_reg[w][AGE_W] && (!hit || (age_of(w) < hit_age)))
            begin
                meta_new[w][AGE_W-1:0] = age_up(age_of(w));
            end
            if (WAY_W'(w) == sel_way)
            begin
                meta_new[w] = {1'b1, {AGE_W{1'b0}}};
                tag_new[w]  = tag_reg;
            end
        end

        look_done = (state_reg == S_LOOK) && (!out_valid_reg || rsp.ready);
        way_ext   = 32'(sel_way);
        set_ext   = 32'(set_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_beat)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (look_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            meta_mem[clr_cnt_reg] <= '0;
        end
        else if (look_done)
        begin
            meta_mem[set_reg] <= meta_new;
        end
        if (look_done && !hit)
        begin
            tag_mem[set_reg] <= tag_new;
        end
        if (req_beat)
        begin
            meta_rd_reg <= meta_mem[set_idx];
            tag_rd_reg  <= tag_mem[set_idx];
            set_reg     <= set_idx;
            tag_reg     <= tag_idx;
        end
        if (look_done)
        begin
            outcome_reg <= outcome_new;
            way_out_reg <= way_ext[WAY_OUT_W-1:0];
            set_out_reg <= set_ext[SET_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            set_bits_reg    <= '0;
            offset_bits_reg <= '0;
            ways_reg        <= 4'd1;
            hits_reg        <= '0;
            misses_reg      <= '0;
            evicts_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_SET_BITS:    set_bits_reg    <= cfg.data[2:0];
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg.data[5:0];
                    CFG_WAYS:        ways_reg        <= cfg.data[3:0];
                    default:         ;
                endcase
            end
            if (look_done)
            begin
                out_valid_reg <= 1'b1;
                if (hit)
                begin
                    hits_reg <= sat_inc(hits_reg);
                end
                else
                begin
                    misses_reg <= sat_inc(misses_reg);
                end
                if (outcome_new == OUTC_EVICT)
                begin
                    evicts_reg <= sat_inc(evicts_reg);
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.outcome        = outcome_reg;
    assign rsp.way_used       = way_out_reg;
    assign rsp.set_used       = set_out_reg;
    assign rsp.hit_total      = hits_reg;
    assign rsp.miss_total     = misses_reg;
    assign rsp.eviction_total = evicts_reg;

endmodule

`default_nettype wire

### rtl/core/salc_checker.sv
// Port-level checker for set_assoc_lru_cache_tags, attached by the bind statement below.
// Depends on salc_pkg for widths and outcome codes.
`default_nettype none

module salc_checker
    import salc_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_ready,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire logic [1:0]           rsp_outcome,
    input wire logic [WAY_OUT_W-1:0] rsp_way_used,
    input wire logic [CNT_W-1:0]     rsp_hit_total,
    input wire logic [CNT_W-1:0]     rsp_eviction_total
);

    // A stalled response beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome) && $stable(rsp_way_used))
        else $error("response beat changed while stalled");

    // One address is in flight at a time, so ready drops right after a request beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a lookup was in flight");

    // A fresh response is traced back to its request beat, through the lookup state and the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response appeared without a matching request");

    // Hits and evictions are counted in the beat that reports them.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_outcome != OUTC_EVICT) || (rsp_eviction_total != '0))
                   && ((rsp_outcome != OUTC_HIT) || (rsp_hit_total != '0)))
        else $error("reported outcome not reflected in its total");

endmodule

bind set_assoc_lru_cache_tags salc_checker u_salc_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_outcome        (rsp.outcome),
    .rsp_way_used       (rsp.way_used),
    .rsp_hit_total      (rsp.hit_total),
    .rsp_eviction_total (rsp.eviction_total)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the set-associative cache tag and LRU replacement engine.
// Holds its own model of tags, ages and totals; depends on salc_pkg, salc_if.sv and the RTL.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import salc_pkg::*;

    localparam int NUM_SETS        = 1 << SALC_MAX_SET_BITS;
    localparam int MAX_IDLE_GAP    = 19;
    localparam int RX_HOLD_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int RANDOM_PHASES   = 16;
    localparam int ITEMS_PER_PHASE = 68;
    localparam int MAX_REPORTS     = 40;

    typedef struct packed {
        outcome_t             outcome;
        logic [WAY_OUT_W-1:0] way_used;
        logic [SET_OUT_W-1:0] set_used;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     miss_total;
        logic [CNT_W-1:0]     eviction_total;
    } lookup_t;

    logic clk = 1'b0;
    logic rst_n;

    salc_cfg_if cfg_ch ();
    salc_req_if req_ch ();
    salc_rsp_if rsp_ch ();

    set_assoc_lru_cache_tags dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    bit                   way_valid [NUM_SETS][SALC_MAX_WAYS];
    logic [ADDR_IN_W-1:0] way_tag   [NUM_SETS][SALC_MAX_WAYS];
    logic [AGE_W-1:0]     way_age   [NUM_SETS][SALC_MAX_WAYS];
    logic [CNT_W-1:0]     hits_expected;
    logic [CNT_W-1:0]     misses_expected;
    logic [CNT_W-1:0]     evict_count;
    logic [2:0]           reg_set_bits;
    logic [5:0]           reg_offset_bits;
    logic [3:0]           reg_ways;

    lookup_t              pending_lookups [$];
    logic [ADDR_IN_W-1:0] recent_addrs [$];
    logic [ADDR_IN_W-1:0] tag_pool [$];
    int                   set_pool [$];

    int errors         = 0;
    int lookups_sent   = 0;
    int results_seen   = 0;
    int fills_seen     = 0;
    int settings_used  = 0;
    int rx_wait        = 0;
    int idle_cycles    = 0;
    bit tx_no_gaps     = 1'b0;
    bit rx_no_stalls   = 1'b0;
    int rx_hold_asks   = 0;
    int rx_holds_taken = 0;

    function automatic logic [AGE_W-1:0] aged(input logic [AGE_W-1:0] a);
        return (&a) ? a : a + 3'd1;
    endfunction

    function automatic logic [CNT_W-1:0] bumped(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 32'd1;
    endfunction

    function automatic int active_set_bits();
        return (reg_set_bits > SALC_MAX_SET_BITS) ? SALC_MAX_SET_BITS : int'(reg_set_bits);
    endfunction

    function automatic int active_ways();
        if (reg_ways == 4'd0)
            return 1;
        return (reg_ways > SALC_MAX_WAYS) ? SALC_MAX_WAYS : int'(reg_ways);
    endfunction

    function automatic void clear_model();
        foreach (way_valid[s, w])
        begin
            way_valid[s][w] = 1'b0;
            way_tag[s][w]   = '0;
            way_age[s][w]   = '0;
        end
        hits_expected   = '0;
        misses_expected = '0;
        evict_count     = '0;
        reg_set_bits    = 3'd0;
        reg_offset_bits = 6'd0;
        reg_ways        = 4'd1;
    endfunction

    function automatic lookup_t predict_lookup(input logic [ADDR_IN_W-1:0] addr);
        int                   sbits;
        int                   nways;
        int                   set_idx;
        int                   w;
        int                   hit_way;
        int                   free_way;
        int                   oldest;
        int                   victim;
        logic [AGE_W-1:0]     hit_age;
        logic [AGE_W-1:0]     oldest_age;
        logic [ADDR_IN_W-1:0] tag;
        lookup_t              r;
        sbits   = active_set_bits();
        nways   = active_ways();
        set_idx = int'((addr >> reg_offset_bits) & ((64'd1 << sbits) - 64'd1));
        tag     = addr >> (sbits + int'(reg_offset_bits));
        hit_way = -1;
        for (w = 0; w < nways; w++)
        begin
            if (way_valid[set_idx][w] && way_tag[set_idx][w] == tag)
            begin
                hit_way = w;
                break;
            end
        end
        if (hit_way >= 0)
        begin
            hit_age = way_age[set_idx][hit_way];
            for (w = 0; w < nways; w++)
                if (way_valid[set_idx][w] && way_age[set_idx][w] < hit_age)
                    way_age[set_idx][w] = aged(way_age[set_idx][w]);
            way_age[set_idx][hit_way] = '0;
            hits_expected = bumped(hits_expected);
            r.outcome     = OUTC_HIT;
            r.way_used    = WAY_OUT_W'(hit_way);
        end
        else
        begin
            free_way        = nways;
            oldest          = 0;
            oldest_age      = '0;
            misses_expected = bumped(misses_expected);
            for (w = 0; w < nways; w++)
            begin
                if (!way_valid[set_idx][w])
                begin
                    free_way = w;
                    break;
                end
                if (way_age[set_idx][w] >= oldest_age)
                begin
                    oldest_age = way_age[set_idx][w];
                    oldest     = w;
                end
            end
            for (w = 0; w < nways; w++)
                if (way_valid[set_idx][w])
                    way_age[set_idx][w] = aged(way_age[set_idx][w]);
            if (free_way < nways)
            begin
                victim    = free_way;
                r.outcome = OUTC_FILL;
                fills_seen++;
            end
            else
            begin
                victim      = oldest;
                r.outcome   = OUTC_EVICT;
                evict_count = bumped(evict_count);
            end
            way_valid[set_idx][victim] = 1'b1;
            way_tag[set_idx][victim]   = tag;
            way_age[set_idx][victim]   = '0;
            r.way_used = WAY_OUT_W'(victim);
        end
        r.set_used       = SET_OUT_W'(set_idx);
        r.hit_total      = hits_expected;
        r.miss_total     = misses_expected;
        r.eviction_total = evict_count;
        return r;
    endfunction

    // Most addresses reuse a few tags and sets so that hits and evictions dominate.
    function automatic logic [ADDR_IN_W-1:0] make_address();
        int                   sbits;
        int                   kind;
        logic [ADDR_IN_W-1:0] offmask;
        logic [ADDR_IN_W-1:0] setmask;
        logic [ADDR_IN_W-1:0] noise;
        logic [ADDR_IN_W-1:0] a;
        sbits   = active_set_bits();
        offmask = (64'd1 << reg_offset_bits) - 64'd1;
        setmask = (64'd1 << sbits) - 64'd1;
        noise   = {$urandom, $urandom};
        kind    = $urandom_range(0, 99);
        if (kind < 10)
            a = noise;
        else if (kind < 45 && recent_addrs.size() > 0)
            a = (recent_addrs[$urandom_range(0, recent_addrs.size() - 1)] & ~offmask)
                | (noise & offmask);
        else
            a = (tag_pool[$urandom_range(0, tag_pool.size() - 1)]
                    << (sbits + int'(reg_offset_bits)))
                | ((64'(set_pool[$urandom_range(0, set_pool.size() - 1)]) & setmask)
                    << reg_offset_bits)
                | (noise & offmask);
        recent_addrs.push_back(a);
        if (recent_addrs.size() > 16)
            void'(recent_addrs.pop_front());
        return a;
    endfunction

    function automatic void new_phase_pools();
        tag_pool.delete();
        set_pool.delete();
        recent_addrs.delete();
        repeat (10)
        begin
            if ($urandom_range(0, 1) == 0)
                tag_pool.push_back(64'($urandom_range(0, 15)));
            else
                tag_pool.push_back({$urandom, $urandom});
        end
        repeat (3)
            set_pool.push_back($urandom_range(0, NUM_SETS - 1));
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        end
    endtask

    task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_SET_BITS:    reg_set_bits    = value[2:0];
            CFG_OFFSET_BITS: reg_offset_bits = value[5:0];
            CFG_WAYS:        reg_ways        = value[3:0];
            default:         ;
        endcase
    endtask

    task automatic write_config(input logic [2:0] set_bits, input logic [5:0] offset_bits,
                                input logic [3:0] ways);
        put_register(CFG_SET_BITS, CFG_DATA_W'(set_bits));
        put_register(CFG_OFFSET_BITS, CFG_DATA_W'(offset_bits));
        put_register(CFG_WAYS, CFG_DATA_W'(ways));
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_lookup(input logic [ADDR_IN_W-1:0] addr);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_IDLE_GAP);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.address <= addr;
        do @(posedge clk); while (!req_ch.ready);
        pending_lookups.push_back(predict_lookup(addr));
        lookups_sent++;
    endtask

    task automatic end_sending();
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_lookup(64'd0);
        send_lookup(64'd0);
        send_lookup('1);
        send_lookup(64'hA5A5_5A5A_0F0F_F0F0);
        end_sending();
        wait_for_results();
    endtask

    task automatic test_address_extremes();
        write_config(3'd7, 6'd63, 4'd15);
        send_lookup('1);
        send_lookup(64'd0);
        send_lookup(64'h8000_0000_0000_0000);
        send_lookup(64'h7FFF_FFFF_FFFF_FFFF);
        end_sending();
        wait_for_results();
        write_config(3'd6, 6'd58, 4'd8);
        send_lookup('1);
        send_lookup(64'h0400_0000_0000_0000);
        send_lookup(64'd0);
        end_sending();
        wait_for_results();
    endtask

    task automatic test_lru_replacement();
        int tag_order [8] = '{0, 1, 2, 3, 1, 4, 0, 3};
        write_config(3'd2, 6'd4, 4'd4);
        foreach (tag_order[i])
            send_lookup((64'(tag_order[i] + 100) << 6) | (64'd1 << 4) | 64'hF);
        end_sending();
        wait_for_results();
        write_config(3'd2, 6'd4, 4'd0);
        send_lookup((64'd101 << 6) | (64'd1 << 4));
        send_lookup((64'd102 << 6) | (64'd1 << 4));
        end_sending();
        wait_for_results();
    endtask

    task automatic test_backpressure();
        write_config(3'd3, 6'd2, 4'd8);
        new_phase_pools();
        tx_no_gaps = 1'b1;
        rx_hold_asks++;
        repeat (24) send_lookup(make_address());
        end_sending();
        wait_for_results();
        tx_no_gaps = 1'b0;
    endtask

    task automatic test_sender_pause();
        write_config(3'd1, 6'd5, 4'd2);
        new_phase_pools();
        repeat (2)
        begin
            repeat (10) send_lookup(make_address());
            end_sending();
            wait_for_results();
        end
    endtask

    task automatic test_random_traffic();
        logic [2:0] corner_sets [8] = '{3'd0, 3'd6, 3'd7, 3'd6, 3'd3, 3'd2, 3'd1, 3'd6};
        logic [5:0] corner_offs [8] = '{6'd0, 6'd0, 6'd63, 6'd32, 6'd6, 6'd60, 6'd3, 6'd58};
        logic [3:0] corner_ways [8] = '{4'd1, 4'd8, 4'd15, 4'd9, 4'd0, 4'd4, 4'd2, 4'd8};
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < 8)
                write_config(corner_sets[phase], corner_offs[phase], corner_ways[phase]);
            else
                write_config(3'($urandom_range(0, 7)),
                             ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                         : 6'($urandom_range(0, 10)),
                             4'($urandom_range(0, 15)));
            new_phase_pools();
            tx_no_gaps   = ($urandom_range(0, 3) == 0);
            rx_no_stalls = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE) send_lookup(make_address());
            end_sending();
            wait_for_results();
        end
        tx_no_gaps   = 1'b0;
        rx_no_stalls = 1'b0;
    endtask

    always @(posedge clk)
    begin : result_side
        lookup_t exp_r;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_lookups.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("Result beat with no lookup outstanding: way %0d set %0d",
                           rsp_ch.way_used, rsp_ch.set_used);
            end
            else
            begin
                exp_r = pending_lookups.pop_front();
                check_field("outcome", 64'(exp_r.outcome), 64'(rsp_ch.outcome));
                check_field("way_used", 64'(exp_r.way_used), 64'(rsp_ch.way_used));
                check_field("set_used", 64'(exp_r.set_used), 64'(rsp_ch.set_used));
                check_field("hit_total", 64'(exp_r.hit_total), 64'(rsp_ch.hit_total));
                check_field("miss_total", 64'(exp_r.miss_total), 64'(rsp_ch.miss_total));
                check_field("eviction_total", 64'(exp_r.eviction_total),
                            64'(rsp_ch.eviction_total));
            end
            rx_wait = rx_no_stalls ? 0 : $urandom_range(0, MAX_IDLE_GAP);
        end
        if (rx_hold_asks != rx_holds_taken)
        begin
            rx_wait = RX_HOLD_CYCLES;
            rx_holds_taken++;
        end
        if (rx_wait > 0)
        begin
            rx_wait--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $error("No beat moved on any channel for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.address <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= CFG_SET_BITS;
        cfg_ch.data    <= '0;
        clear_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_address_extremes();
        test_lru_replacement();
        test_backpressure();
        test_sender_pause();
        test_random_traffic();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d lookups over %0d register settings:", lookups_sent, settings_used);
        $display("%0d hits, %0d fills, %0d evictions.", hits_expected, fills_seen, evict_count);
        $display("Checked %0d result beats, %0d mismatches found.", results_seen, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### set_assoc_lru_cache_tags.f
rtl/core/salc_pkg.sv
rtl/core/salc_if.sv
rtl/core/set_assoc_lru_cache_tags.sv
rtl/core/salc_checker.sv
tb/tb_top.sv
